>>> hw/rtl/idr_pkg.sv
// Shared widths, codes and command types for the inertial dead-reckoning block.
package idr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 16;
    localparam int FUNC_W      = 2;
    localparam int AXES        = 3;
    localparam int VEL_W       = 48;
    localparam int POS_W       = 64;
    localparam int LO_W        = VEL_W / 2;
    localparam int HI_W        = VEL_W - LO_W;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int DT_W        = TIME_BITS + 1;
    localparam int MA_W        = (DIFF_W > LO_W + 1) ? DIFF_W : LO_W + 1;
    localparam int MP_W        = MA_W + DT_W;
    localparam int ADDV_W      = ((MP_W > VEL_W) ? MP_W : VEL_W) + 1;
    localparam int CMB_W       = ((MP_W + LO_W + 1) > POS_W) ? (MP_W + LO_W + 1) : (POS_W + 1);
    localparam int PSUM_W      = POS_W + 1;

    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_RST_POS = 2'd1,
        FUNC_RST_VEL = 2'd2
    } t_func;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_ANG = 2'd3;

    // Phases of one axis; the angle pass uses the first two only
    localparam logic [2:0] PH_DIFF = 3'd0;
    localparam logic [2:0] PH_VEL  = 3'd1;
    localparam logic [2:0] PH_VLO  = 3'd2;
    localparam logic [2:0] PH_VHI  = 3'd3;
    localparam logic [2:0] PH_CMB  = 3'd4;
    localparam logic [2:0] PH_POS  = 3'd5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SET_RATE,
        OP_CLR_POS,
        OP_CLR_VEL,
        OP_MUL_DIFF,
        OP_ADD_VEL,
        OP_MUL_VLO,
        OP_MUL_VHI,
        OP_COMBINE,
        OP_ADD_POS,
        OP_MUL_RATE,
        OP_ADD_ANG
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RUN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       capture;
        t_op        op;
        logic [1:0] axis;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
    } t_status;

    function automatic t_op step_op(input logic [1:0] axis, input logic [2:0] phase);
        t_op op;
        if (axis == AXIS_ANG) begin
            op = (phase == PH_DIFF) ? OP_MUL_RATE : OP_ADD_ANG;
        end else begin
            case (phase)
                PH_DIFF: op = OP_MUL_DIFF;
                PH_VEL:  op = OP_ADD_VEL;
                PH_VLO:  op = OP_MUL_VLO;
                PH_VHI:  op = OP_MUL_VHI;
                PH_CMB:  op = OP_COMBINE;
                default: op = OP_ADD_POS;
            endcase
        end
        return op;
    endfunction

endpackage

>>> hw/rtl/idr_ctrl.sv
// Sequencer: accepts beats, steps the datapath through its operations, owns output valid.
module idr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  idr_pkg::t_status   i_status,
    output idr_pkg::t_cmd      o_cmd
);

    idr_pkg::t_state r_state, n_state;
    logic [1:0]      r_axis, n_axis;
    logic [2:0]      r_phase, n_phase;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= idr_pkg::ST_IDLE;
            r_axis      <= idr_pkg::AXIS_X;
            r_phase     <= idr_pkg::PH_DIFF;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_phase  = r_phase;
        o_cmd    = '0;
        o_cmd.op = idr_pkg::OP_NONE;
        case (r_state)
            idr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = idr_pkg::ST_DISPATCH;
                end
            end
            idr_pkg::ST_DISPATCH: begin
                n_state = idr_pkg::ST_OUT;
                case (i_status.func)
                    idr_pkg::FUNC_SAMPLE: begin
                        o_cmd.op = idr_pkg::OP_SET_RATE;
                        n_axis   = idr_pkg::AXIS_X;
                        n_phase  = idr_pkg::PH_DIFF;
                        n_state  = idr_pkg::ST_RUN;
                    end
                    idr_pkg::FUNC_RST_POS: o_cmd.op = idr_pkg::OP_CLR_POS;
                    idr_pkg::FUNC_RST_VEL: o_cmd.op = idr_pkg::OP_CLR_VEL;
                    default:               o_cmd.op = idr_pkg::OP_NONE;
                endcase
            end
            idr_pkg::ST_RUN: begin
                o_cmd.op   = idr_pkg::step_op(r_axis, r_phase);
                o_cmd.axis = r_axis;
                if (r_axis == idr_pkg::AXIS_ANG && r_phase == idr_pkg::PH_VEL) begin
                    n_state = idr_pkg::ST_OUT;
                end else if (r_phase == idr_pkg::PH_POS) begin
                    n_phase = idr_pkg::PH_DIFF;
                    n_axis  = r_axis + 2'd1;
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            idr_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = idr_pkg::ST_IDLE;
                end
            end
            default: n_state = idr_pkg::ST_IDLE;
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_ready = (r_state == idr_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> hw/rtl/idr_datapath.sv
// Accumulators, shared multiplier, saturating adders and result register.
module idr_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  idr_pkg::t_cmd                          i_cmd,
    output idr_pkg::t_status                       o_status,
    input  logic [idr_pkg::FUNC_W-1:0]             i_func,
    input  logic signed [idr_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [idr_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [idr_pkg::SAMPLE_BITS-1:0] i_accel_z,
    input  logic signed [idr_pkg::SAMPLE_BITS-1:0] i_gyro_rate,
    input  logic [idr_pkg::TIME_BITS-1:0]          i_elapsed_us,
    output logic signed [idr_pkg::POS_W-1:0]       o_pos_x,
    output logic signed [idr_pkg::POS_W-1:0]       o_pos_y,
    output logic signed [idr_pkg::POS_W-1:0]       o_pos_z,
    output logic signed [idr_pkg::VEL_W-1:0]       o_vel_x,
    output logic signed [idr_pkg::VEL_W-1:0]       o_vel_y,
    output logic signed [idr_pkg::VEL_W-1:0]       o_vel_z,
    output logic signed [idr_pkg::VEL_W-1:0]       o_heading,
    output logic signed [idr_pkg::SAMPLE_BITS-1:0] o_turn_rate
);

    localparam int SB = idr_pkg::SAMPLE_BITS;
    localparam int VW = idr_pkg::VEL_W;
    localparam int PW = idr_pkg::POS_W;
    localparam int LW = idr_pkg::LO_W;
    localparam int AV = idr_pkg::ADDV_W;
    localparam int CW = idr_pkg::CMB_W;
    localparam int SW = idr_pkg::PSUM_W;
    localparam int MP = idr_pkg::MP_W;
    localparam int MA = idr_pkg::MA_W;

    // captured beat
    logic [idr_pkg::FUNC_W-1:0]    r_func;
    logic signed [SB-1:0]          r_accel [0:idr_pkg::AXES-1];
    logic signed [SB-1:0]          r_rate_in;
    logic [idr_pkg::TIME_BITS-1:0] r_dt;

    // integrator state
    logic signed [VW-1:0] r_vel  [0:idr_pkg::AXES-1];
    logic signed [PW-1:0] r_pos  [0:idr_pkg::AXES-1];
    logic signed [SB-1:0] r_grav [0:idr_pkg::AXES-1];
    logic signed [VW-1:0] r_ang;
    logic signed [SB-1:0] r_rate;

    // multiplier pipeline
    logic signed [MP-1:0] r_prod;
    logic signed [MP-1:0] r_lo;
    logic signed [PW-1:0] r_term;

    logic signed [SB-1:0]              sel_acc, sel_grav;
    logic signed [VW-1:0]              sel_vel;
    logic signed [PW-1:0]              sel_pos;
    logic signed [idr_pkg::DIFF_W-1:0] diff;
    logic signed [MA-1:0]              mul_a;
    logic signed [idr_pkg::DT_W-1:0]   dt_s;
    logic signed [MP-1:0]              prod;
    logic signed [AV-1:0]              vsum, asum;
    logic signed [CW-1:0]              csum;
    logic signed [SW-1:0]              psum;
    logic [VW-1:0]                     vel_new, ang_new;
    logic [PW-1:0]                     term_new, pos_new;

    always_comb begin
        case (i_cmd.axis)
            idr_pkg::AXIS_X: begin
                sel_acc = r_accel[0]; sel_grav = r_grav[0];
                sel_vel = r_vel[0];   sel_pos  = r_pos[0];
            end
            idr_pkg::AXIS_Y: begin
                sel_acc = r_accel[1]; sel_grav = r_grav[1];
                sel_vel = r_vel[1];   sel_pos  = r_pos[1];
            end
            default: begin
                sel_acc = r_accel[2]; sel_grav = r_grav[2];
                sel_vel = r_vel[2];   sel_pos  = r_pos[2];
            end
        endcase

        diff = idr_pkg::DIFF_W'(sel_acc) - idr_pkg::DIFF_W'(sel_grav);
        dt_s = signed'({1'b0, r_dt});

        case (i_cmd.op)
            idr_pkg::OP_MUL_DIFF: mul_a = MA'(diff);
            idr_pkg::OP_MUL_VLO:  mul_a = MA'({1'b0, sel_vel[LW-1:0]});
            idr_pkg::OP_MUL_VHI:  mul_a = MA'($signed(sel_vel[VW-1:LW]));
            idr_pkg::OP_MUL_RATE: mul_a = MA'(r_rate_in);
            default:              mul_a = '0;
        endcase
        prod = mul_a * dt_s;

        // speed and angle: add product, clamp to 48 bits
        vsum = AV'(sel_vel) + AV'(r_prod);
        if (vsum[AV-1:VW-1] == {(AV-VW+1){vsum[AV-1]}}) begin
            vel_new = vsum[VW-1:0];
        end else begin
            vel_new = vsum[AV-1] ? idr_pkg::VEL_MIN : idr_pkg::VEL_MAX;
        end

        asum = AV'(r_ang) + AV'(r_prod);
        if (asum[AV-1:VW-1] == {(AV-VW+1){asum[AV-1]}}) begin
            ang_new = asum[VW-1:0];
        end else begin
            ang_new = asum[AV-1] ? idr_pkg::VEL_MIN : idr_pkg::VEL_MAX;
        end

        // join the two speed partial products, clamp to 64 bits
        csum = (CW'(r_prod) <<< LW) + CW'(r_lo);
        if (csum[CW-1:PW-1] == {(CW-PW+1){csum[CW-1]}}) begin
            term_new = csum[PW-1:0];
        end else begin
            term_new = csum[CW-1] ? idr_pkg::POS_MIN : idr_pkg::POS_MAX;
        end

        psum = SW'(sel_pos) + SW'(r_term);
        if (psum[SW-1] == psum[SW-2]) begin
            pos_new = psum[PW-1:0];
        end else begin
            pos_new = psum[SW-1] ? idr_pkg::POS_MIN : idr_pkg::POS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < idr_pkg::AXES; i++) begin
                r_vel[i]  <= '0;
                r_pos[i]  <= '0;
                r_grav[i] <= '0;
            end
            r_ang  <= '0;
            r_rate <= '0;
        end else begin
            case (i_cmd.op)
                idr_pkg::OP_SET_RATE: r_rate <= r_rate_in;
                idr_pkg::OP_CLR_POS: begin
                    for (int i = 0; i < idr_pkg::AXES; i++) begin
                        r_pos[i] <= '0;
                    end
                    r_ang <= '0;
                end
                idr_pkg::OP_CLR_VEL: begin
                    for (int i = 0; i < idr_pkg::AXES; i++) begin
                        r_vel[i]  <= '0;
                        r_grav[i] <= r_accel[i];
                    end
                    r_rate <= '0;
                end
                idr_pkg::OP_ADD_VEL: r_vel[i_cmd.axis] <= vel_new;
                idr_pkg::OP_ADD_POS: r_pos[i_cmd.axis] <= pos_new;
                idr_pkg::OP_ADD_ANG: r_ang <= ang_new;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= i_func;
            r_accel[0] <= i_accel_x;
            r_accel[1] <= i_accel_y;
            r_accel[2] <= i_accel_z;
            r_rate_in  <= i_gyro_rate;
            r_dt       <= i_elapsed_us;
        end
        if (i_cmd.op inside {idr_pkg::OP_MUL_DIFF, idr_pkg::OP_MUL_VLO,
                             idr_pkg::OP_MUL_VHI, idr_pkg::OP_MUL_RATE}) begin
            r_prod <= prod;
        end
        // keep the low partial product while the high one is formed
        if (i_cmd.op == idr_pkg::OP_MUL_VHI) begin
            r_lo <= r_prod;
        end
        if (i_cmd.op == idr_pkg::OP_COMBINE) begin
            r_term <= term_new;
        end
        if (i_cmd.load_out) begin
            o_pos_x     <= r_pos[0];
            o_pos_y     <= r_pos[1];
            o_pos_z     <= r_pos[2];
            o_vel_x     <= r_vel[0];
            o_vel_y     <= r_vel[1];
            o_vel_z     <= r_vel[2];
            o_heading   <= r_ang;
            o_turn_rate <= r_rate;
        end
    end

    assign o_status.func = r_func;

endmodule

>>> hw/rtl/inertial_dead_reckoning.sv
// Top level: a sample beat is worked through by one shared 25x17 multiplier, stepping over
// three axes (six steps each) and the angle (two steps) before o_valid is raised.
// Reset-position and reset-speed beats skip the multiplier steps. The block returns to idle
// as the result is registered and takes no new beat before that: one beat is in flight at a time.
// The result register lets the next beat start while a result waits to be taken.
// Synchronous active-low reset clears speed, position, gravity, angle, rate and valid.
module inertial_dead_reckoning (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [idr_pkg::FUNC_W-1:0]             i_func,
    input  logic signed [idr_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [idr_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [idr_pkg::SAMPLE_BITS-1:0] i_accel_z,
    input  logic signed [idr_pkg::SAMPLE_BITS-1:0] i_gyro_rate,
    input  logic [idr_pkg::TIME_BITS-1:0]          i_elapsed_us,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [idr_pkg::POS_W-1:0]       o_pos_x,
    output logic signed [idr_pkg::POS_W-1:0]       o_pos_y,
    output logic signed [idr_pkg::POS_W-1:0]       o_pos_z,
    output logic signed [idr_pkg::VEL_W-1:0]       o_vel_x,
    output logic signed [idr_pkg::VEL_W-1:0]       o_vel_y,
    output logic signed [idr_pkg::VEL_W-1:0]       o_vel_z,
    output logic signed [idr_pkg::VEL_W-1:0]       o_heading,
    output logic signed [idr_pkg::SAMPLE_BITS-1:0] o_turn_rate
);

    idr_pkg::t_cmd    cmd;
    idr_pkg::t_status status;

    idr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    idr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_func       (i_func),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_gyro_rate  (i_gyro_rate),
        .i_elapsed_us (i_elapsed_us),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_vel_x      (o_vel_x),
        .o_vel_y      (o_vel_y),
        .o_vel_z      (o_vel_z),
        .o_heading    (o_heading),
        .o_turn_rate  (o_turn_rate)
    );

endmodule

>>> hw/rtl/idr_checker.sv
// Port-level checks for the dead-reckoning block, bound to the top level.
module idr_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_ready,
    input logic [idr_pkg::FUNC_W-1:0]             i_func,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic signed [idr_pkg::POS_W-1:0]       o_pos_x,
    input logic signed [idr_pkg::VEL_W-1:0]       o_vel_x,
    input logic signed [idr_pkg::VEL_W-1:0]       o_vel_y,
    input logic signed [idr_pkg::VEL_W-1:0]       o_vel_z,
    input logic signed [idr_pkg::VEL_W-1:0]       o_heading,
    input logic signed [idr_pkg::SAMPLE_BITS-1:0] o_turn_rate
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pos_x) && $stable(o_vel_x)
                                && $stable(o_heading))
        else $error("result beat changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again while a beat is in flight");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");

    a_rst_vel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid && i_func == idr_pkg::FUNC_RST_VEL
        |-> ##3 (o_valid && o_vel_x == '0 && o_vel_y == '0 && o_vel_z == '0
                 && o_turn_rate == '0))
        else $error("reset-speed beat did not return zero speed and rate");

endmodule

bind inertial_dead_reckoning idr_checker u_idr_checker (.*);
